// ===== src/ttt_pkg.sv =====
// Shared types and constants for the trapezoid travel time core.
package ttt_pkg;

    localparam int unsigned SPEED_BITS  = 20;
    localparam int unsigned ACCEL_BITS  = 24;
    localparam int unsigned RESULT_BITS = 32;
    localparam int unsigned CELL_COUNT  = 32;
    localparam int unsigned ROOT_BITS   = 31;
    localparam int unsigned RAD_BITS    = 62;
    localparam int unsigned PROD_BITS   = 56;
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SPEED    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACCELERATION = 2'd1;

    localparam logic [9:0]  MS_PER_S  = 10'd1000;
    localparam logic [21:0] TRI_SCALE = 22'd4000000;

    typedef struct packed {
        logic                   zero;
        logic                   is_tri;
        logic                   satq;
        logic [SPEED_BITS-1:0]  rem_a;
        logic [31:0]            num_a;
        logic [31:0]            quo_a;
        logic [ACCEL_BITS-1:0]  rem_b;
        logic [31:0]            num_b;
        logic [31:0]            quo_b;
        logic [RAD_BITS-1:0]    x;
        logic [RAD_BITS-1:0]    s;
        logic [PROD_BITS-1:0]   t;
        logic [ROOT_BITS-1:0]   root;
    } cell_t;

endpackage

// ===== src/ttt_cell.sv =====
// One step cell: a quotient bit of both dividers and, for bit positions below ROOT_BITS, a bit of the root.
module ttt_cell
    import ttt_pkg::*;
#(
    parameter int unsigned BIT_POS = 0
)(
    input  logic                  clk,
    input  logic                  en,
    input  logic [SPEED_BITS-1:0] speed,
    input  logic [ACCEL_BITS-1:0] accel,
    input  cell_t                 cell_in,
    output cell_t                 cell_out
);

    localparam int unsigned CW = 88;

    cell_t                  cell_next;
    cell_t                  cell_reg;
    logic [SPEED_BITS:0]    ta;
    logic [SPEED_BITS:0]    da;
    logic                   ga;
    logic [ACCEL_BITS:0]    tb;
    logic [ACCEL_BITS:0]    db;
    logic                   gb;
    logic [RAD_BITS-1:0]    s_new;
    logic [PROD_BITS-1:0]   t_new;
    logic [ROOT_BITS-1:0]   root_new;

    assign ta = {cell_in.rem_a, cell_in.num_a[BIT_POS]};
    assign da = ta - {1'b0, speed};
    assign ga = (ta >= {1'b0, speed});
    assign tb = {cell_in.rem_b, cell_in.num_b[BIT_POS]};
    assign db = tb - {1'b0, accel};
    assign gb = (tb >= {1'b0, accel});

    generate
        if (BIT_POS < ROOT_BITS) begin : g_root
            logic [CW-1:0] cand;
            logic          sq_take;
            always_comb
            begin
                cand = CW'(cell_in.s) + (CW'(cell_in.t) << (BIT_POS + 1))
                     + (CW'(accel) << (2 * BIT_POS));
                sq_take  = (cand <= CW'(cell_in.x));
                s_new    = sq_take ? cand[RAD_BITS-1:0] : cell_in.s;
                t_new    = sq_take ? (cell_in.t + (PROD_BITS'(accel) << BIT_POS)) : cell_in.t;
                root_new = cell_in.root;
                root_new[BIT_POS] = sq_take;
            end
        end else begin : g_noroot
            assign s_new    = cell_in.s;
            assign t_new    = cell_in.t;
            assign root_new = cell_in.root;
        end
    endgenerate

    always_comb
    begin
        cell_next = cell_in;
        cell_next.rem_a = ga ? da[SPEED_BITS-1:0] : ta[SPEED_BITS-1:0];
        cell_next.quo_a[BIT_POS] = ga;
        cell_next.rem_b = gb ? db[ACCEL_BITS-1:0] : tb[ACCEL_BITS-1:0];
        cell_next.quo_b[BIT_POS] = gb;
        cell_next.s    = s_new;
        cell_next.t    = t_new;
        cell_next.root = root_new;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ===== src/trapezoid_travel_time_core.sv =====
// Throughput: one request per cycle while the skid entry is empty; 32 step cells each
// resolve one quotient bit of both dividers, and all but the first one root bit.
// Backpressure: a two-entry output stage lets the pipe run one request past a stalled output.
// Reset: asynchronous active low; clears valid bits and both registers to zero.
module trapezoid_travel_time_core
    import ttt_pkg::*;
#(
    parameter int unsigned POSITION_BITS = 32
)(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [POSITION_BITS-1:0] start_position,
    input  logic signed [POSITION_BITS-1:0] target_position,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [RESULT_BITS-1:0]          travel_ms,
    output logic                            triangular,
    output logic                            saturated,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_data
);

    localparam int unsigned PB  = POSITION_BITS;
    localparam int unsigned DW  = PB + 1;
    localparam int unsigned DXW = (DW > 41) ? DW : 41;
    localparam int unsigned NXW = (DW + 10 > 52) ? DW + 10 : 52;

    logic [SPEED_BITS-1:0] speed_reg;
    logic [ACCEL_BITS-1:0] accel_reg;

    logic en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= '0;
            accel_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MAX_SPEED:    speed_reg <= cfg_data[SPEED_BITS-1:0];
                REG_ACCELERATION: accel_reg <= cfg_data[ACCEL_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // stage 1: distance
    logic [PB-1:0] sign_bit;
    logic [PB-1:0] from_off;
    logic [PB-1:0] to_off;
    logic [DW-1:0] dist_next;
    logic [DW-1:0] dist_reg;
    logic          s1_valid_reg;

    assign sign_bit  = PB'(1) << (PB - 1);
    assign from_off  = $unsigned(start_position) ^ sign_bit;
    assign to_off    = $unsigned(target_position) ^ sign_bit;
    assign dist_next = (to_off > from_off) ? ({1'b0, to_off} - {1'b0, from_off})
                                           : ({1'b0, from_off} - {1'b0, to_off});

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            dist_reg <= dist_next;
        end
    end

    // stage 2: products
    logic [DXW-1:0]  dx;
    logic [39:0]     d40;
    logic [43:0]     plo_reg;
    logic [43:0]     phi_reg;
    logic [39:0]     vv_reg;
    logic            big_reg;
    logic [RAD_BITS-1:0] x_reg;
    logic [NXW-1:0]  n1_reg;
    logic [29:0]     nv_reg;
    logic            zero2_reg;
    logic            s2_valid_reg;

    assign dx  = DXW'(dist_reg);
    assign d40 = dx[39:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg   <= 44'(d40[19:0]) * 44'(accel_reg);
            phi_reg   <= 44'(d40[39:20]) * 44'(accel_reg);
            vv_reg    <= 40'(speed_reg) * 40'(speed_reg);
            big_reg   <= |dx[DXW-1:40];
            x_reg     <= RAD_BITS'(d40) * RAD_BITS'(TRI_SCALE);
            n1_reg    <= NXW'(dist_reg) * NXW'(MS_PER_S);
            nv_reg    <= 30'(speed_reg) * 30'(MS_PER_S);
            zero2_reg <= (dist_reg == '0) || (speed_reg == '0) || (accel_reg == '0);
        end
    end

    // stage 3: classification and cell chain entry
    logic [63:0] da_sum;
    cell_t       chain [CELL_COUNT+1];
    cell_t       head_next;
    cell_t       head_reg;
    logic        s3_valid_reg;

    assign da_sum = 64'(plo_reg) + (64'(phi_reg) << 20);

    always_comb
    begin
        head_next        = '0;
        head_next.zero   = zero2_reg;
        head_next.is_tri = !big_reg && (da_sum < 64'(vv_reg));
        head_next.satq   = (n1_reg[NXW-1:32] >= (NXW-32)'(speed_reg));
        head_next.rem_a  = n1_reg[51:32];
        head_next.num_a  = n1_reg[31:0];
        head_next.num_b  = 32'(nv_reg);
        head_next.x      = x_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head_reg <= head_next;
        end
    end

    assign chain[0] = head_reg;

    logic [CELL_COUNT-1:0] cell_valid_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CELL_COUNT; gi++)
        begin : g_cell
            ttt_cell #(
                .BIT_POS(CELL_COUNT - 1 - gi)
            ) u_cell (
                .clk      (clk),
                .en       (en),
                .speed    (speed_reg),
                .accel    (accel_reg),
                .cell_in  (chain[gi]),
                .cell_out (chain[gi+1])
            );
        end
    endgenerate

    // final stage 1: remainder cross products
    cell_t tail;
    logic [43:0] m1_reg;
    logic [43:0] m2_reg;
    logic [43:0] av_reg;
    logic [32:0] qs_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic        zero_f_reg;
    logic        tri_f_reg;
    logic        satq_f_reg;
    logic        f1_valid_reg;

    assign tail = chain[CELL_COUNT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg     <= 44'(tail.rem_a) * 44'(accel_reg);
            m2_reg     <= 44'(tail.rem_b) * 44'(speed_reg);
            av_reg     <= 44'(accel_reg) * 44'(speed_reg);
            qs_reg     <= 33'(tail.quo_a) + 33'(tail.quo_b);
            root_reg   <= tail.root;
            zero_f_reg <= tail.zero;
            tri_f_reg  <= tail.is_tri;
            satq_f_reg <= tail.satq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            cell_valid_reg <= '0;
            f1_valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg   <= in_valid;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            cell_valid_reg <= {cell_valid_reg[CELL_COUNT-2:0], s3_valid_reg};
            f1_valid_reg   <= cell_valid_reg[CELL_COUNT-1];
        end
    end

    // result assembly
    logic [44:0]            msum;
    logic [32:0]            total;
    logic [RESULT_BITS-1:0] res_ms;
    logic                   res_tri;
    logic                   res_sat;

    always_comb
    begin
        msum  = 45'(m1_reg) + 45'(m2_reg);
        total = qs_reg + 33'(msum >= 45'(av_reg));
        res_ms  = '0;
        res_tri = 1'b0;
        res_sat = 1'b0;
        if (!zero_f_reg)
        begin
            if (tri_f_reg)
            begin
                res_ms  = 32'(root_reg);
                res_tri = 1'b1;
            end
            else if (satq_f_reg || total[32])
            begin
                res_ms  = '1;
                res_sat = 1'b1;
            end
            else
            begin
                res_ms = total[31:0];
            end
        end
    end

    // output register and skid entry
    logic                   out_valid_reg;
    logic [RESULT_BITS-1:0] out_ms_reg;
    logic                   out_tri_reg;
    logic                   out_sat_reg;
    logic                   skid_valid_reg;
    logic [RESULT_BITS-1:0] skid_ms_reg;
    logic                   skid_tri_reg;
    logic                   skid_sat_reg;
    logic                   fire_out;
    logic                   arrive;

    assign en       = !skid_valid_reg;
    assign in_ready = en;
    assign fire_out = out_valid_reg && out_ready;
    assign arrive   = f1_valid_reg && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (fire_out)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !fire_out)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (fire_out)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (fire_out)
            begin
                out_ms_reg  <= skid_ms_reg;
                out_tri_reg <= skid_tri_reg;
                out_sat_reg <= skid_sat_reg;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !fire_out)
            begin
                skid_ms_reg  <= res_ms;
                skid_tri_reg <= res_tri;
                skid_sat_reg <= res_sat;
            end
            else
            begin
                out_ms_reg  <= res_ms;
                out_tri_reg <= res_tri;
                out_sat_reg <= res_sat;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign travel_ms  = out_ms_reg;
    assign triangular = out_tri_reg;
    assign saturated  = out_sat_reg;

endmodule

// ===== src/ttt_checker.sv =====
// Port-level checks for the trapezoid travel time core, bound to the top level.
module ttt_checker
    import ttt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [RESULT_BITS-1:0] travel_ms,
    input logic                   triangular,
    input logic                   saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(travel_ms))
        else $error("result changed while stalled");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> travel_ms == 32'hFFFF_FFFF)
        else $error("saturated result not at maximum");

    a_tri_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && triangular |-> !saturated)
        else $error("triangular result flagged saturated");

    a_tri_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && triangular |-> !travel_ms[31])
        else $error("triangular root out of range");

endmodule

bind trapezoid_travel_time_core ttt_checker u_ttt_checker (.*);
